[src/iba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iba_pkg: shared definitions for the integer binary-op ALU
// Opcodes, status codes, default width and the control word that rides
// along the cell chain.
// ----------------------------------------------------------------------------
package iba_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [4:0] {
		OP_MUL  = 5'd0,
		OP_DIV  = 5'd1,
		OP_ADD  = 5'd2,
		OP_SUB  = 5'd3,
		OP_EQ   = 5'd4,
		OP_NE   = 5'd5,
		OP_GT   = 5'd6,
		OP_LT   = 5'd7,
		OP_GE   = 5'd8,
		OP_LE   = 5'd9,
		OP_LAND = 5'd10,
		OP_LOR  = 5'd11,
		OP_OR   = 5'd12,
		OP_XOR  = 5'd13,
		OP_AND  = 5'd14,
		OP_SRA  = 5'd15,
		OP_SHL  = 5'd16
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NOT_NUM = 2'd1,
		STATUS_DIV0    = 2'd2
	} status_t;

	// control word carried next to the data through every cell
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    is_mul;  // cells run one shift-add step
		logic    is_div;  // cells run one restoring-divide step
		logic    neg_q;   // quotient sign fix at the end
	} ctl_t;

endpackage

[src/integer_binary_op_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_binary_op_alu: pipelined two-operand integer ALU
//
// channel  | handshake     | payload
// ---------+---------------+------------------------------------------------
// command  | start / busy  | operation, left_value, right_value,
//          |               | left_is_number, right_is_number
// result   | done (strobe) | result_value, status
//
// Every op passes through one decode stage, a chain of DATA_WIDTH cells
// (one multiply bit or one quotient bit per cell) and an output register.
// The chain takes a new item every cycle, so busy is
// never raised. Reset clears only the control words along the chain and
// done. The receiver cannot stall: each result shows for one cycle with
// done high.
// ----------------------------------------------------------------------------
module integer_binary_op_alu import iba_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [4:0]                   operation,
	input  logic signed [DATA_WIDTH-1:0] left_value,
	input  logic signed [DATA_WIDTH-1:0] right_value,
	input  logic                         left_is_number,
	input  logic                         right_is_number,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic [1:0]                   status
);

	// chain taps: index 0 is the decode stage output, DATA_WIDTH the last cell
	ctl_t                  ctl_c [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] a_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] b_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] c_c   [DATA_WIDTH+1];

	ctl_t                  ctl_end;
	logic [DATA_WIDTH-1:0] res_d;
	logic                  done_q;
	logic [DATA_WIDTH-1:0] result_q;
	status_t               status_q;

	// fully pipelined: never refuses a command
	assign busy = 1'b0;

	iba_front #(.W(DATA_WIDTH)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.operation       (operation),
		.left_value      (left_value),
		.right_value     (right_value),
		.left_is_number  (left_is_number),
		.right_is_number (right_is_number),
		.ctl_s1          (ctl_c[0]),
		.a_s1            (a_c[0]),
		.b_s1            (b_c[0]),
		.c_s1            (c_c[0])
	);

	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
		iba_cell #(.W(DATA_WIDTH)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[k]),
			.a_in    (a_c[k]),
			.b_in    (b_c[k]),
			.c_in    (c_c[k]),
			.ctl_out (ctl_c[k+1]),
			.a_out   (a_c[k+1]),
			.b_out   (b_c[k+1]),
			.c_out   (c_c[k+1])
		);
	end

	assign ctl_end = ctl_c[DATA_WIDTH];

	// Divide leaves the quotient magnitude in b, which the sign fix negates;
	// most-negative / -1 wraps back to most-negative. Everything else ends in c.
	always_comb begin
		if (ctl_end.is_div) begin
			res_d = ctl_end.neg_q ? (-b_c[DATA_WIDTH]) : b_c[DATA_WIDTH];
		end else begin
			res_d = c_c[DATA_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		status_q <= ctl_end.status;
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;

endmodule

[src/iba_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iba_front: operand decode stage
// Checks operands, computes the ops that need no cell chain and loads the cell chain
// for multiply and divide. One registered stage.
// ----------------------------------------------------------------------------
module iba_front import iba_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [4:0]          operation,
	input  logic signed [W-1:0] left_value,
	input  logic signed [W-1:0] right_value,
	input  logic                left_is_number,
	input  logic                right_is_number,
	output ctl_t                ctl_s1,
	output logic [W-1:0]        a_s1,
	output logic [W-1:0]        b_s1,
	output logic [W-1:0]        c_s1
);

	ctl_t         ctl_d;
	logic [W-1:0] a_d, b_d, c_d;
	logic [W-1:0] l_mag, r_mag;
	logic [4:0]   shamt;

	assign shamt = right_value[4:0];
	assign l_mag = left_value[W-1]  ? (-left_value)  : left_value;
	assign r_mag = right_value[W-1] ? (-right_value) : right_value;

	always_comb begin
		ctl_d.valid  = start;
		ctl_d.status = STATUS_OK;
		ctl_d.is_mul = 1'b0;
		ctl_d.is_div = 1'b0;
		ctl_d.neg_q  = left_value[W-1] ^ right_value[W-1];
		a_d = '0;
		b_d = '0;
		c_d = '0;
		if (!left_is_number || !right_is_number) begin
			ctl_d.status = STATUS_NOT_NUM;
		end else begin
			case (op_t'(operation))
				OP_MUL: begin
					ctl_d.is_mul = 1'b1;
					a_d = left_value;
					b_d = right_value;
				end
				OP_DIV: begin
					if (right_value == '0) begin
						ctl_d.status = STATUS_DIV0;
					end else begin
						ctl_d.is_div = 1'b1;
						a_d = r_mag;
						b_d = l_mag;
					end
				end
				OP_ADD:  c_d = left_value + right_value;
				OP_SUB:  c_d = left_value - right_value;
				OP_EQ:   c_d = {{(W-1){1'b0}}, left_value == right_value};
				OP_NE:   c_d = {{(W-1){1'b0}}, left_value != right_value};
				OP_GT:   c_d = {{(W-1){1'b0}}, left_value >  right_value};
				OP_LT:   c_d = {{(W-1){1'b0}}, left_value <  right_value};
				OP_GE:   c_d = {{(W-1){1'b0}}, left_value >= right_value};
				OP_LE:   c_d = {{(W-1){1'b0}}, left_value <= right_value};
				OP_LAND: c_d = {{(W-1){1'b0}}, (left_value != '0) && (right_value != '0)};
				OP_LOR:  c_d = {{(W-1){1'b0}}, (left_value != '0) || (right_value != '0)};
				OP_OR:   c_d = left_value | right_value;
				OP_XOR:  c_d = left_value ^ right_value;
				OP_AND:  c_d = left_value & right_value;
				// only the low five bits of right_value set the shift amount
				OP_SRA:  c_d = left_value >>> shamt;
				OP_SHL:  c_d = left_value << shamt;
				default: c_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_d;
		b_s1 <= b_d;
		c_s1 <= c_d;
	end

endmodule

[src/iba_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iba_cell: one step of the multiply / divide chain
// Multiply: acc += mplier[0] ? mcand : 0, then shift the pair.
// Divide: one restoring step, quotient bit shifted into the dividend word.
// Other ops pass straight through.
// ----------------------------------------------------------------------------
module iba_cell import iba_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  ctl_t         ctl_in,
	input  logic [W-1:0] a_in,   // mcand / divisor
	input  logic [W-1:0] b_in,   // mplier / dividend-quotient
	input  logic [W-1:0] c_in,   // product acc / partial remainder
	output ctl_t         ctl_out,
	output logic [W-1:0] a_out,
	output logic [W-1:0] b_out,
	output logic [W-1:0] c_out
);

	logic [W-1:0] rem_sh;
	logic [W:0]   diff;
	logic         fits;
	logic [W-1:0] a_d, b_d, c_d;

	// remainder stays below the divisor, so its top bit is always clear
	assign rem_sh = {c_in[W-2:0], b_in[W-1]};
	assign diff   = {1'b0, rem_sh} - {1'b0, a_in};
	assign fits   = ~diff[W];

	always_comb begin
		a_d = a_in;
		b_d = b_in;
		c_d = c_in;
		if (ctl_in.is_div) begin
			c_d = fits ? diff[W-1:0] : rem_sh;
			b_d = {b_in[W-2:0], fits};
		end else if (ctl_in.is_mul) begin
			c_d = c_in + (b_in[0] ? a_in : '0);
			a_d = {a_in[W-2:0], 1'b0};
			b_d = {1'b0, b_in[W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		a_out <= a_d;
		b_out <= b_d;
		c_out <= c_d;
	end

endmodule
